### hw/rtl/clt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the compacting list table.
// No dependencies; used by clt_cell and compacting_list_table_unit.
package clt_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = 5;
    localparam int DATA_W  = 32;
    localparam int CAP_RST = 10;

    typedef enum logic [2:0] {
        OP_APPEND    = 3'd0,
        OP_DROP_LAST = 3'd1,
        OP_DROP_AT   = 3'd2,
        OP_DROP_VAL  = 3'd3,
        OP_CLEAR     = 3'd4,
        OP_READ      = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    // Broadcast command seen by every cell in the chain.
    typedef struct packed {
        logic                append_en;
        logic                drop_at_en;
        logic                drop_val_en;
        logic [CNT_W-1:0]    count;
        logic [CNT_W-1:0]    position;
        logic [DATA_W-1:0]   value;
    } cell_cmd_t;

endpackage

### hw/rtl/clt_cell.sv
`timescale 1ns / 1ps
// One slot of the list: holds an entry, matches it, shifts from its neighbor.
// Depends on clt_pkg.
module clt_cell
(
    input  logic                          clk,
    input  logic [clt_pkg::IDX_W-1:0]     idx,
    input  clt_pkg::cell_cmd_t            cmd,
    input  logic [clt_pkg::DATA_W-1:0]    next_data,
    input  logic                          hit_in,
    output logic                          hit_out,
    output logic [clt_pkg::DATA_W-1:0]    data
);

    logic [clt_pkg::DATA_W-1:0] data_reg;
    logic [clt_pkg::DATA_W-1:0] data_next;
    logic [clt_pkg::CNT_W-1:0]  idx_ext;
    logic                       valid;
    logic                       match;
    logic                       shift;
    logic                       load;

    assign idx_ext = clt_pkg::CNT_W'(idx);
    assign valid   = idx_ext < cmd.count;
    assign match   = valid && (data_reg == cmd.value);
    assign hit_out = hit_in | match;

    // drop-at: cells at or past the 1-based position pull from the right
    assign shift = (cmd.drop_val_en && (hit_in || match))
                || (cmd.drop_at_en && ((idx_ext + clt_pkg::CNT_W'(1)) >= cmd.position));
    assign load  = cmd.append_en && (idx_ext == cmd.count);

    always_comb
    begin
        priority if (load)
        begin
            data_next = cmd.value;
        end
        else if (shift)
        begin
            data_next = next_data;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

### hw/rtl/compacting_list_table_unit.sv
`timescale 1ns / 1ps
// Top level of the compacting list table: command port, capacity register, cell chain.
// Depends on clt_pkg and clt_cell.
//
// A command is taken when start is high and busy is low. Busy then stays high for
// one cycle while the cell chain works the operation; at the end of that cycle the
// list updates and done pulses for one cycle with status, count and read_value.
// The receiver cannot stall the result, so it must capture it on the done cycle.
// A new command can be taken on the done cycle. All cells compare and shift in
// parallel, so deletes cost no more than appends. The capacity register (cfg_data,
// reset 10) is always ready and should be written while idle; values above the
// list depth act as the depth.
module compacting_list_table_unit
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [2:0]                            op,
    input  logic signed [clt_pkg::DATA_W-1:0]     value,
    input  logic [clt_pkg::CNT_W-1:0]             position,
    output logic                                  done,
    output logic [2:0]                            status,
    output logic [clt_pkg::CNT_W-1:0]             count,
    output logic signed [clt_pkg::DATA_W-1:0]     read_value,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [clt_pkg::CNT_W-1:0]             cfg_data
);

    // control state
    logic                          busy_reg;
    logic                          busy_next;
    logic                          done_reg;
    logic                          done_next;
    logic [clt_pkg::CNT_W-1:0]     count_reg;
    logic [clt_pkg::CNT_W-1:0]     count_next;
    logic [clt_pkg::CNT_W-1:0]     cap_reg;

    // latched command
    clt_pkg::op_t                  op_reg;
    logic [clt_pkg::DATA_W-1:0]    value_reg;
    logic [clt_pkg::CNT_W-1:0]     pos_reg;

    // result registers
    clt_pkg::status_t              status_reg;
    clt_pkg::status_t              status_next;
    logic [clt_pkg::DATA_W-1:0]    rd_reg;
    logic [clt_pkg::DATA_W-1:0]    rd_next;

    logic                          accept;
    logic [clt_pkg::CNT_W-1:0]     cap_eff;
    logic                          found;
    clt_pkg::cell_cmd_t            cmd;

    logic [clt_pkg::DATA_W-1:0]    cell_data [clt_pkg::DEPTH];
    logic                          hit [clt_pkg::DEPTH+1];

    assign accept    = start && !busy_reg;
    assign cfg_ready = 1'b1;

    // capacity clamps at the list depth
    assign cap_eff = (cap_reg > clt_pkg::CNT_W'(clt_pkg::DEPTH))
                   ? clt_pkg::CNT_W'(clt_pkg::DEPTH) : cap_reg;

    // operation decode for the execute cycle
    always_comb
    begin
        status_next     = clt_pkg::ST_OK;
        count_next      = count_reg;
        rd_next         = '0;
        cmd.append_en   = 1'b0;
        cmd.drop_at_en  = 1'b0;
        cmd.drop_val_en = 1'b0;
        cmd.count       = count_reg;
        cmd.position    = pos_reg;
        cmd.value       = value_reg;
        unique case (op_reg)
            clt_pkg::OP_APPEND:
            begin
                if (({1'b0, count_reg} + (clt_pkg::CNT_W+1)'(1)) < {1'b0, cap_eff})
                begin
                    cmd.append_en = busy_reg;
                    count_next    = count_reg + clt_pkg::CNT_W'(1);
                end
                else
                begin
                    status_next = clt_pkg::ST_FULL;
                end
            end
            clt_pkg::OP_DROP_LAST:
            begin
                if (count_reg == '0)
                    status_next = clt_pkg::ST_EMPTY;
                else
                    count_next = count_reg - clt_pkg::CNT_W'(1);
            end
            clt_pkg::OP_DROP_AT:
            begin
                priority if (count_reg == '0)
                    status_next = clt_pkg::ST_EMPTY;
                else if (pos_reg == '0 || pos_reg > count_reg)
                    status_next = clt_pkg::ST_BADPOS;
                else
                begin
                    cmd.drop_at_en = busy_reg;
                    count_next     = count_reg - clt_pkg::CNT_W'(1);
                end
            end
            clt_pkg::OP_DROP_VAL:
            begin
                // cells gate their own shift on the hit chain
                cmd.drop_val_en = busy_reg;
                if (found)
                    count_next = count_reg - clt_pkg::CNT_W'(1);
                else
                    status_next = clt_pkg::ST_NOTFOUND;
            end
            clt_pkg::OP_CLEAR:
            begin
                count_next = '0;
            end
            clt_pkg::OP_READ:
            begin
                priority if (count_reg == '0)
                    status_next = clt_pkg::ST_EMPTY;
                else if (pos_reg >= count_reg)
                    status_next = clt_pkg::ST_BADPOS;
                else
                    rd_next = cell_data[pos_reg[clt_pkg::IDX_W-1:0]];
            end
            default:
            begin
                status_next = clt_pkg::ST_OK;
            end
        endcase
    end

    // cell chain: each cell pulls from its right neighbor on a shift; the last cell reloads its own data
    assign hit[0] = 1'b0;
    for (genvar k = 0; k < clt_pkg::DEPTH; k++)
    begin : g_cell
        logic [clt_pkg::DATA_W-1:0] right_data;
        if (k == clt_pkg::DEPTH - 1)
        begin : g_last
            assign right_data = cell_data[k];
        end
        else
        begin : g_mid
            assign right_data = cell_data[k+1];
        end
        clt_cell u_cell
        (
            .clk       (clk),
            .idx       (clt_pkg::IDX_W'(k)),
            .cmd       (cmd),
            .next_data (right_data),
            .hit_in    (hit[k]),
            .hit_out   (hit[k+1]),
            .data      (cell_data[k])
        );
    end
    assign found = hit[clt_pkg::DEPTH];

    assign busy_next = accept ? 1'b1 : 1'b0;
    assign done_next = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
            cap_reg   <= clt_pkg::CNT_W'(clt_pkg::CAP_RST);
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            if (busy_reg)
                count_reg <= count_next;
            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= clt_pkg::op_t'(op);
            value_reg <= value;
            pos_reg   <= position;
        end
        if (busy_reg)
        begin
            status_reg <= status_next;
            rd_reg     <= rd_next;
        end
    end

    assign busy       = busy_reg;
    assign done       = done_reg;
    assign status     = status_reg;
    assign count      = count_reg;
    assign read_value = rd_reg;

    // checks
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("done without execute cycle");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && done_reg))
        else $error("busy and done together");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= clt_pkg::CNT_W'(clt_pkg::DEPTH - 1))
        else $error("count past depth");

    a_fail_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != clt_pkg::ST_OK) |-> count_reg == $past(count_reg))
        else $error("failed op changed count");

    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != clt_pkg::ST_OK) |-> rd_reg == '0)
        else $error("failed op returned data");

endmodule
